### hw/rtl/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg
// Types and constants shared by the serial command frame parser modules.
// ----------------------------------------------------------------------------
package scfp_pkg;

	localparam logic [7:0] CH_START = 8'h26;
	localparam logic [7:0] CH_STOP  = 8'h24;
	localparam logic [7:0] CH_SEP   = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ACK   = 8'h41;

	localparam logic [1:0] K_CMD       = 2'd0;
	localparam logic [1:0] K_MSG       = 2'd1;
	localparam logic [1:0] K_BLOCK_END = 2'd2;
	localparam logic [1:0] K_REPLY     = 2'd3;

	// depth of the queue between parser and result generator
	localparam int QDEPTH = 4;

	// one unit of work handed from the parser to the result generator
	typedef struct packed {
		logic       reply;
		logic [1:0] kind;
		logic [7:0] value;
		logic [1:0] blk;
		logic [5:0] pos;
		logic [7:0] sender;
		logic [1:0] blocks;
		logic [7:0] ack;
		logic [7:0] check;
	} job_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'd0, d};
		end else begin
			r = 8'h57 + {4'd0, d};
		end
		return r;
	endfunction

endpackage

### hw/rtl/scfp_front.sv
// ----------------------------------------------------------------------------
// scfp_front
// Frame parser: walks the frame one byte per cycle while the job queue has
// room, and queues a job for every byte that causes results.
// ----------------------------------------------------------------------------
module scfp_front import scfp_pkg::*; #(
	parameter int MAX_BLOCKS  = 3,
	parameter int COMMAND_CAP = 4,
	parameter int MESSAGE_CAP = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	input  logic       full,
	output logic       push,
	output job_t       job
);

	localparam int BW = $clog2(MAX_BLOCKS + 1);
	localparam int CW = $clog2(COMMAND_CAP);
	localparam int MW = $clog2(MESSAGE_CAP);

	typedef enum logic [6:0] {
		PH_HUNT  = 7'b0000001,
		PH_ID    = 7'b0000010,
		PH_COUNT = 7'b0000100,
		PH_CMD   = 7'b0001000,
		PH_MSG   = 7'b0010000,
		PH_ACKID = 7'b0100000,
		PH_CHECK = 7'b1000000
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [7:0]      sender_q, sender_d;
	logic [BW-1:0]   blocks_q, blocks_d;
	logic [BW-1:0]   remain_q, remain_d;
	logic [BW-1:0]   cur_blk_q, cur_blk_d;
	logic [CW-1:0]   cmd_pos_q, cmd_pos_d;
	logic [MW-1:0]   msg_pos_q, msg_pos_d;
	logic [7:0]      ack_q, ack_d;
	logic [7:0]      check_q, check_d;
	logic            take;
	logic            need_job;
	logic [7:0]      digit;
	logic [BW-1:0]   clamped;
	logic [BW-1:0]   remain_dec;

	assign rx_ready = !full;
	assign take     = rx_valid && rx_ready;
	assign push     = take && need_job;
	assign digit    = rx_byte - CH_ZERO;

	always_comb begin
		if (digit < 8'd1) begin
			clamped = BW'(1);
		end else if (digit > 8'(MAX_BLOCKS)) begin
			clamped = BW'(MAX_BLOCKS);
		end else begin
			clamped = BW'(digit);
		end
	end

	assign remain_dec = (remain_q != '0) ? remain_q - BW'(1) : remain_q;

	always_comb begin
		phase_d   = phase_q;
		sender_d  = sender_q;
		blocks_d  = blocks_q;
		remain_d  = remain_q;
		cur_blk_d = cur_blk_q;
		cmd_pos_d = cmd_pos_q;
		msg_pos_d = msg_pos_q;
		ack_d     = ack_q;
		check_d   = check_q;
		need_job  = 1'b0;
		job.reply  = 1'b0;
		job.kind   = K_CMD;
		job.value  = rx_byte;
		job.blk    = 2'(cur_blk_q);
		job.pos    = 6'(cmd_pos_q);
		job.sender = sender_q;
		job.blocks = 2'(blocks_q);
		job.ack    = ack_q;
		job.check  = check_q;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == CH_START) begin
					sender_d  = '0;
					blocks_d  = '0;
					remain_d  = '0;
					cur_blk_d = '0;
					cmd_pos_d = '0;
					msg_pos_d = '0;
					phase_d   = PH_ID;
				end
			end
			PH_ID: begin
				if (rx_byte == CH_SEP) begin
					phase_d = PH_COUNT;
				end else begin
					sender_d = rx_byte;
				end
			end
			PH_COUNT: begin
				if (rx_byte == CH_SEP) begin
					// missing digit counts as one
					blocks_d = (blocks_q == '0) ? BW'(1) : blocks_q;
					remain_d = (blocks_q == '0) ? BW'(1) : blocks_q;
					phase_d  = PH_CMD;
				end else begin
					blocks_d = clamped;
				end
			end
			PH_CMD: begin
				if (rx_byte == CH_SEP) begin
					phase_d = PH_MSG;
				end else begin
					need_job  = 1'b1;
					cmd_pos_d = (cmd_pos_q == CW'(COMMAND_CAP - 1)) ? '0
						: cmd_pos_q + CW'(1);
				end
			end
			PH_MSG: begin
				need_job = 1'b1;
				job.pos  = 6'(msg_pos_q);
				if (rx_byte == CH_SEP) begin
					job.kind  = K_BLOCK_END;
					job.value = 8'(cmd_pos_q);
					cmd_pos_d = '0;
					msg_pos_d = '0;
					cur_blk_d = cur_blk_q + BW'(1);
					remain_d  = remain_dec;
					phase_d   = (remain_dec == '0) ? PH_ACKID : PH_CMD;
				end else begin
					job.kind  = K_MSG;
					msg_pos_d = (msg_pos_q == MW'(MESSAGE_CAP - 1)) ? '0
						: msg_pos_q + MW'(1);
				end
			end
			PH_ACKID: begin
				if (rx_byte == CH_SEP) begin
					phase_d = PH_CHECK;
				end else begin
					ack_d = rx_byte;
				end
			end
			PH_CHECK: begin
				if (rx_byte == CH_STOP) begin
					need_job  = 1'b1;
					job.reply = 1'b1;
					job.kind  = K_REPLY;
					job.value = CH_START;
					job.blk   = '0;
					job.pos   = '0;
					phase_d   = PH_HUNT;
				end else begin
					check_d = rx_byte;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			sender_q  <= '0;
			blocks_q  <= '0;
			remain_q  <= '0;
			cur_blk_q <= '0;
			cmd_pos_q <= '0;
			msg_pos_q <= '0;
			ack_q     <= '0;
			check_q   <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			sender_q  <= sender_d;
			blocks_q  <= blocks_d;
			remain_q  <= remain_d;
			cur_blk_q <= cur_blk_d;
			cmd_pos_q <= cmd_pos_d;
			msg_pos_q <= msg_pos_d;
			ack_q     <= ack_d;
			check_q   <= check_d;
		end
	end

endmodule

### hw/rtl/scfp_fifo.sv
// ----------------------------------------------------------------------------
// scfp_fifo
// Small job queue between the parser and the result generator.
// ----------------------------------------------------------------------------
module scfp_fifo import scfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int AW = $clog2(QDEPTH);
	localparam int NW = $clog2(QDEPTH + 1);

	job_t          mem_q [QDEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == NW'(QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QDEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QDEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

### hw/rtl/scfp_back.sv
// ----------------------------------------------------------------------------
// scfp_back
// Result generator: turns queued jobs into result words, expanding a reply
// job into its four or five reply bytes, through an output register.
// ----------------------------------------------------------------------------
module scfp_back import scfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  job_t       head,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic [1:0] block_index,
	output logic [5:0] position,
	output logic [7:0] sender_id,
	output logic [1:0] declared_blocks,
	output logic [7:0] ack_code,
	output logic [7:0] check_byte,
	output logic       frame_done,
	output logic       last
);

	typedef enum logic [4:0] {
		RS_IDLE = 5'b00001,
		RS_ACK  = 5'b00010,
		RS_HI   = 5'b00100,
		RS_LO   = 5'b01000,
		RS_STOP = 5'b10000
	} rstep_t;

	rstep_t     step_q, step_d;
	job_t       rep_q;
	logic       load;
	logic       gen_valid;
	job_t       gen;
	logic       gen_done;
	logic       gen_last;
	logic       out_valid_q;
	job_t       out_q;
	logic       done_q;
	logic       last_q;

	assign load = !out_valid_q || res_ready;

	always_comb begin
		step_d    = step_q;
		gen_valid = 1'b0;
		gen       = rep_q;
		gen_done  = 1'b0;
		gen_last  = 1'b0;
		pop       = 1'b0;
		case (step_q)
			RS_IDLE: begin
				gen = head;
				if (!empty) begin
					gen_valid = 1'b1;
					pop       = load;
					if (head.reply) begin
						step_d = RS_ACK;
					end else begin
						gen_last = 1'b1;
					end
				end
			end
			RS_ACK: begin
				gen_valid = 1'b1;
				gen.value = CH_ACK;
				step_d    = (rep_q.ack >= 8'd16) ? RS_HI : RS_LO;
			end
			RS_HI: begin
				gen_valid = 1'b1;
				gen.value = hex_char(rep_q.ack[7:4]);
				step_d    = RS_LO;
			end
			RS_LO: begin
				gen_valid = 1'b1;
				gen.value = hex_char(rep_q.ack[3:0]);
				step_d    = RS_STOP;
			end
			RS_STOP: begin
				gen_valid = 1'b1;
				gen.value = CH_STOP;
				gen_done  = 1'b1;
				gen_last  = 1'b1;
				step_d    = RS_IDLE;
			end
			default: begin
				step_d = RS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= RS_IDLE;
			out_valid_q <= 1'b0;
		end else if (load) begin
			step_q      <= step_d;
			out_valid_q <= gen_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= gen;
			done_q <= gen_done;
			last_q <= gen_last;
			if (pop) begin
				rep_q <= head;
			end
		end
	end

	assign res_valid       = out_valid_q;
	assign kind            = out_q.kind;
	assign value           = out_q.value;
	assign block_index     = out_q.blk;
	assign position        = out_q.pos;
	assign sender_id       = out_q.sender;
	assign declared_blocks = out_q.blocks;
	assign ack_code        = out_q.ack;
	assign check_byte      = out_q.check;
	assign frame_done      = done_q;
	assign last            = last_q;

endmodule

### hw/rtl/serial_command_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_command_frame_parser_unit
// Receive-side frame parser: emits command and message bytes, block ends
// and the acknowledge reply for frames '&id:n:cmd:msg:...:ack:chk$'.
//
//   channel  | handshake            | payload
//   rx       | rx_valid / rx_ready  | rx_byte
//   result   | res_valid / res_ready| kind value block_index position sender_id
//            |                      | declared_blocks ack_code check_byte
//            |                      | frame_done last
//
// One byte is accepted per cycle while the four-entry job queue has room.
// A result passes the job queue and the result generator's output register;
// a stop byte gives four or five reply words, one per cycle unless stalled.
// Reset puts the parser into start hunting and empties queue and output.
// A stalled result side fills the queue, then drops rx_ready.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_unit import scfp_pkg::*; #(
	parameter int MAX_BLOCKS  = 3,
	parameter int COMMAND_CAP = 4,
	parameter int MESSAGE_CAP = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic [1:0] block_index,
	output logic [5:0] position,
	output logic [7:0] sender_id,
	output logic [1:0] declared_blocks,
	output logic [7:0] ack_code,
	output logic [7:0] check_byte,
	output logic       frame_done,
	output logic       last
);

	logic push;
	logic pop;
	logic empty;
	logic full;
	job_t job;
	job_t head;

	scfp_front #(
		.MAX_BLOCKS  (MAX_BLOCKS),
		.COMMAND_CAP (COMMAND_CAP),
		.MESSAGE_CAP (MESSAGE_CAP)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.full     (full),
		.push     (push),
		.job      (job)
	);

	scfp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (job),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	scfp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (empty),
		.head            (head),
		.pop             (pop),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.kind            (kind),
		.value           (value),
		.block_index     (block_index),
		.position        (position),
		.sender_id       (sender_id),
		.declared_blocks (declared_blocks),
		.ack_code        (ack_code),
		.check_byte      (check_byte),
		.frame_done      (frame_done),
		.last            (last)
	);

endmodule

### hw/rtl/scfp_checker.sv
// ----------------------------------------------------------------------------
// scfp_checker
// Port-level checks on the result channel of the frame parser.
// ----------------------------------------------------------------------------
module scfp_checker import scfp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] kind,
	input logic [7:0] value,
	input logic       frame_done,
	input logic       last
);

	// a stalled result keeps its word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value) && $stable(kind))
		else $error("result changed while stalled");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> kind == K_REPLY && value == CH_STOP && last)
		else $error("frame done on a word other than the closing reply byte");

	// payload bytes and block ends are one word per byte
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != K_REPLY |-> last && !frame_done)
		else $error("data word not marked last");

	a_reply_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == K_REPLY && last |-> frame_done)
		else $error("reply ended without frame done");

endmodule

bind serial_command_frame_parser_unit scfp_checker u_scfp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.kind       (kind),
	.value      (value),
	.frame_done (frame_done),
	.last       (last)
);
